FILE: design/mwrf_pkg.sv
// Shared constants, action codes and helpers for the multiword ring FIFO.
`default_nettype none
package mwrf_pkg;

  localparam int DEPTH    = 64;
  localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int COUNT_W  = 7;
  localparam int WORD_W   = 16;
  localparam int ACTION_W = 3;

  typedef logic [ADDR_W-1:0]  addr_t;
  typedef logic [COUNT_W-1:0] count_t;
  typedef logic [WORD_W-1:0]  word_t;

  typedef enum logic [ACTION_W-1:0] {
    ACT_PUSH_TWO   = 3'd0,
    ACT_PUSH_THREE = 3'd1,
    ACT_POP        = 3'd2,
    ACT_PEEK       = 3'd3,
    ACT_FLUSH      = 3'd4
  } action_t;

  // A push is taken whole only while fewer than DEPTH-3 words are stored.
  localparam count_t PUSH_LIMIT = COUNT_W'(DEPTH - 3);
  localparam addr_t  LAST_ADDR  = ADDR_W'(DEPTH - 1);

  function automatic addr_t ptr_inc(input addr_t p);
    addr_t n;
    if (p == LAST_ADDR) begin
      n = '0;
    end else begin
      n = p + addr_t'(1);
    end
    return n;
  endfunction

endpackage
`default_nettype wire

FILE: design/multiword_ring_fifo_top.sv
// Top level of the multiword ring FIFO: command sequencer around the word RAM.
//
//   channel   handshake          ports
//   command   start / busy       action, first_word, second_word, third_word
//   result    done (one cycle)   read_word, was_empty, push_dropped, fill_count
//
// A push writes its first word as the item is taken, then its second and, for a
// three-word push, its third, one per write through the single RAM port. Pop and peek
// register the RAM word in ST_READ. Flush, refused pushes, empty reads and unused codes
// answer at once. A push result appears the cycle after the last RAM write. Each result
// comes as busy drops, so a new item may start in the cycle that carries the previous
// result. Synchronous reset empties the FIFO at once; the RAM contents are not cleared.
`default_nettype none
module multiword_ring_fifo_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  action,
  input  wire logic [15:0] first_word,
  input  wire logic [15:0] second_word,
  input  wire logic [15:0] third_word,
  output logic             done,
  output logic [15:0]      read_word,
  output logic             was_empty,
  output logic             push_dropped,
  output logic [6:0]       fill_count
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WR_SECOND,
    ST_WR_THIRD,
    ST_READ
  } state_t;

  state_t              state;
  mwrf_pkg::addr_t     wptr;
  mwrf_pkg::addr_t     rptr;
  mwrf_pkg::count_t    count;
  mwrf_pkg::word_t     second_q;
  mwrf_pkg::word_t     third_q;
  logic                three_q;
  logic                pop_q;

  logic                accept;
  logic                is_push;
  logic                is_read;
  logic                room;
  logic                ram_we;
  mwrf_pkg::addr_t     ram_addr;
  mwrf_pkg::word_t     ram_wdata;
  mwrf_pkg::word_t     ram_rdata;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;
  assign room   = (count < mwrf_pkg::PUSH_LIMIT);

  always_comb begin
    is_push = 1'b0;
    is_read = 1'b0;
    unique case (action) inside
      mwrf_pkg::ACT_PUSH_TWO, mwrf_pkg::ACT_PUSH_THREE: is_push = 1'b1;
      mwrf_pkg::ACT_POP, mwrf_pkg::ACT_PEEK:            is_read = 1'b1;
      default: ;
    endcase
  end

  // The first word of a push is written in the cycle the item is taken.
  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = wptr;
    ram_wdata = first_word;
    unique case (state)
      ST_IDLE: begin
        ram_we   = accept && is_push && room;
        ram_addr = is_read ? rptr : wptr;
      end
      ST_WR_SECOND: begin
        ram_we    = 1'b1;
        ram_wdata = second_q;
      end
      ST_WR_THIRD: begin
        ram_we    = 1'b1;
        ram_wdata = third_q;
      end
      ST_READ: ;
      default: ;
    endcase
  end

  mwrf_ram #(
    .WIDTH (mwrf_pkg::WORD_W),
    .DEPTH (mwrf_pkg::DEPTH),
    .ADDR_W(mwrf_pkg::ADDR_W)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      wptr         <= '0;
      rptr         <= '0;
      count        <= '0;
      three_q      <= 1'b0;
      pop_q        <= 1'b0;
      done         <= 1'b0;
      read_word    <= '0;
      was_empty    <= 1'b0;
      push_dropped <= 1'b0;
      fill_count   <= '0;
    end else begin
      done <= 1'b0;
      unique case (state) inside
        ST_IDLE: begin
          if (accept) begin
            second_q <= second_word;
            third_q  <= third_word;
            three_q  <= (action == mwrf_pkg::ACT_PUSH_THREE);
            pop_q    <= (action == mwrf_pkg::ACT_POP);
            if (is_push && room) begin
              wptr  <= mwrf_pkg::ptr_inc(wptr);
              count <= count + mwrf_pkg::count_t'(1);
              state <= ST_WR_SECOND;
            end else if (is_read && (count != '0)) begin
              state <= ST_READ;
            end else begin
              // Answered at once: refused push, empty read, flush or unused code.
              done         <= 1'b1;
              read_word    <= '0;
              was_empty    <= is_read;
              push_dropped <= is_push;
              if (action == mwrf_pkg::ACT_FLUSH) begin
                wptr       <= '0;
                rptr       <= '0;
                count      <= '0;
                fill_count <= '0;
              end else begin
                fill_count <= count;
              end
            end
          end
        end
        ST_WR_SECOND, ST_WR_THIRD: begin
          wptr  <= mwrf_pkg::ptr_inc(wptr);
          count <= count + mwrf_pkg::count_t'(1);
          if (state == ST_WR_SECOND && three_q) begin
            state <= ST_WR_THIRD;
          end else begin
            state        <= ST_IDLE;
            done         <= 1'b1;
            read_word    <= '0;
            was_empty    <= 1'b0;
            push_dropped <= 1'b0;
            fill_count   <= count + mwrf_pkg::count_t'(1);
          end
        end
        ST_READ: begin
          state        <= ST_IDLE;
          done         <= 1'b1;
          read_word    <= ram_rdata;
          was_empty    <= 1'b0;
          push_dropped <= 1'b0;
          if (pop_q) begin
            rptr       <= mwrf_pkg::ptr_inc(rptr);
            count      <= count - mwrf_pkg::count_t'(1);
            fill_count <= count - mwrf_pkg::count_t'(1);
          end else begin
            fill_count <= count;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // The fill count can never reach the full depth, since a push needs room for three.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= mwrf_pkg::COUNT_W'(mwrf_pkg::DEPTH - 1))
    else $error("fill count beyond depth");

  // An empty FIFO has its pointers together.
  a_empty_ptrs: assert property (@(posedge clk) disable iff (rst)
    (count == '0) |-> (wptr == rptr))
    else $error("pointers apart while empty");

  // The reported fill count matches the internal count on every result.
  a_fill_match: assert property (@(posedge clk) disable iff (rst)
    done |-> (fill_count == count))
    else $error("reported fill count differs from internal count");

  // A result never carries both flags.
  a_flags_excl: assert property (@(posedge clk) disable iff (rst)
    done |-> !(was_empty && push_dropped))
    else $error("both result flags set");

  // A read returns data only when it found a stored word.
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (done && was_empty) |-> (read_word == '0))
    else $error("empty read returned data");

endmodule
`default_nettype wire

FILE: design/mwrf_ram.sv
// Single-port synchronous RAM with a registered read port.
`default_nettype none
module mwrf_ram #(
  parameter int WIDTH  = 16,
  parameter int DEPTH  = 64,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] addr,
  input  wire logic [WIDTH-1:0]  wdata,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire

FILE: sim/testbench.sv
// Self-checking testbench for the multiword ring FIFO: random and directed item streams.
`timescale 1ns / 100ps
module testbench;

  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_ITEMS = 1700;
  localparam int QUIET_TAIL = 250;
  localparam int MAX_PRINTS = 50;
  localparam logic [2:0] ACT_SPARE_LO = 3'd5;
  localparam logic [2:0] ACT_SPARE_HI = 3'd7;
  localparam int MODE_FILL = 0;
  localparam int MODE_DRAIN = 1;
  localparam int MODE_MIXED = 2;

  typedef struct packed {
    logic [2:0]      action;
    mwrf_pkg::word_t w1;
    mwrf_pkg::word_t w2;
    mwrf_pkg::word_t w3;
    logic            hold;
  } fifo_cmd_t;

  typedef struct packed {
    mwrf_pkg::word_t  read_word;
    logic             was_empty;
    logic             push_dropped;
    mwrf_pkg::count_t fill_count;
  } fifo_outcome_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [2:0] action = '0;
  logic [15:0] first_word = '0;
  logic [15:0] second_word = '0;
  logic [15:0] third_word = '0;
  logic busy;
  logic done;
  logic [15:0] read_word;
  logic was_empty;
  logic push_dropped;
  logic [6:0] fill_count;

  multiword_ring_fifo_top i_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .action       (action),
    .first_word   (first_word),
    .second_word  (second_word),
    .third_word   (third_word),
    .done         (done),
    .read_word    (read_word),
    .was_empty    (was_empty),
    .push_dropped (push_dropped),
    .fill_count   (fill_count)
  );

  always #5 clk = ~clk;

  // Shadow copy of the FIFO contents and pointers.
  mwrf_pkg::word_t  shadow_ram [mwrf_pkg::DEPTH];
  mwrf_pkg::addr_t  shadow_wr = '0;
  mwrf_pkg::addr_t  shadow_rd = '0;
  mwrf_pkg::count_t shadow_count = '0;

  fifo_cmd_t     cmd_queue[$];
  fifo_outcome_t expected_results[$];
  fifo_cmd_t     cur_cmd;
  int            in_flight = 0;
  int            gap_left = 0;
  int            error_count = 0;
  int            cycle_count = 0;

  function automatic mwrf_pkg::addr_t wrap_inc(input mwrf_pkg::addr_t p);
    return (p == mwrf_pkg::addr_t'(mwrf_pkg::DEPTH - 1)) ? mwrf_pkg::addr_t'(0)
                                                         : p + mwrf_pkg::addr_t'(1);
  endfunction

  function automatic void append_word(input mwrf_pkg::word_t w);
    shadow_ram[shadow_wr] = w;
    shadow_wr = wrap_inc(shadow_wr);
    shadow_count = shadow_count + mwrf_pkg::count_t'(1);
  endfunction

  function automatic fifo_outcome_t predict_outcome(input fifo_cmd_t c);
    fifo_outcome_t o;
    o = '0;
    case (c.action) inside
      mwrf_pkg::ACT_PUSH_TWO, mwrf_pkg::ACT_PUSH_THREE: begin
        if (shadow_count < mwrf_pkg::count_t'(mwrf_pkg::DEPTH - 3)) begin
          append_word(c.w1);
          append_word(c.w2);
          if (c.action == mwrf_pkg::ACT_PUSH_THREE) begin
            append_word(c.w3);
          end
        end else begin
          o.push_dropped = 1'b1;
        end
      end
      mwrf_pkg::ACT_POP, mwrf_pkg::ACT_PEEK: begin
        if (shadow_count != '0) begin
          o.read_word = shadow_ram[shadow_rd];
          if (c.action == mwrf_pkg::ACT_POP) begin
            shadow_rd = wrap_inc(shadow_rd);
            shadow_count = shadow_count - mwrf_pkg::count_t'(1);
          end
        end else begin
          o.was_empty = 1'b1;
        end
      end
      mwrf_pkg::ACT_FLUSH: begin
        shadow_wr = '0;
        shadow_rd = '0;
        shadow_count = '0;
      end
      default: begin
      end
    endcase
    o.fill_count = shadow_count;
    return o;
  endfunction

  function automatic mwrf_pkg::word_t rand_word();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return mwrf_pkg::word_t'($urandom);
    endcase
  endfunction

  function automatic fifo_cmd_t make_cmd(input logic [2:0] a, input mwrf_pkg::word_t x,
                                         input mwrf_pkg::word_t y, input mwrf_pkg::word_t z,
                                         input logic hold);
    fifo_cmd_t c;
    c.action = a;
    c.w1 = x;
    c.w2 = y;
    c.w3 = z;
    c.hold = hold;
    return c;
  endfunction

  // The mode skews the mix of actions so that the store is driven to full and back to empty.
  function automatic fifo_cmd_t random_cmd(input int mode);
    int roll;
    logic [2:0] a;
    roll = $urandom_range(0, 99);
    case (mode)
      MODE_FILL: begin
        if (roll < 45) a = mwrf_pkg::ACT_PUSH_TWO;
        else if (roll < 85) a = mwrf_pkg::ACT_PUSH_THREE;
        else if (roll < 94) a = mwrf_pkg::ACT_POP;
        else a = mwrf_pkg::ACT_PEEK;
      end
      MODE_DRAIN: begin
        if (roll < 10) a = mwrf_pkg::ACT_PUSH_TWO;
        else if (roll < 20) a = mwrf_pkg::ACT_PUSH_THREE;
        else if (roll < 75) a = mwrf_pkg::ACT_POP;
        else if (roll < 92) a = mwrf_pkg::ACT_PEEK;
        else if (roll < 97) a = 3'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI));
        else a = mwrf_pkg::ACT_FLUSH;
      end
      default: begin
        if (roll < 25) a = mwrf_pkg::ACT_PUSH_TWO;
        else if (roll < 50) a = mwrf_pkg::ACT_PUSH_THREE;
        else if (roll < 75) a = mwrf_pkg::ACT_POP;
        else if (roll < 90) a = mwrf_pkg::ACT_PEEK;
        else if (roll < 95) a = 3'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI));
        else a = mwrf_pkg::ACT_FLUSH;
      end
    endcase
    return make_cmd(a, rand_word(), rand_word(), rand_word(), 1'b0);
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    if (error_count < MAX_PRINTS) begin
      $display("ERROR at %0t ns: %s got 0x%0h expected 0x%0h", $time, what, got, want);
    end
    error_count++;
  endtask

  // Driver: an item is taken at an edge where start is high and busy is low.
  always @(posedge clk) begin
    logic next_start;
    next_start = start;
    if (!rst) begin
      if (start && !busy) begin
        expected_results.push_back(predict_outcome(cur_cmd));
        in_flight++;
        next_start = 1'b0;
        if (cmd_queue.size() > QUIET_TAIL && $urandom_range(0, 3) == 0) begin
          gap_left = $urandom_range(1, 8);
        end
      end
      if (done) begin
        in_flight--;
      end
      if (!next_start) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (cmd_queue.size() > 0 && (!cmd_queue[0].hold || in_flight == 0)) begin
          cur_cmd = cmd_queue.pop_front();
          action <= cur_cmd.action;
          first_word <= cur_cmd.w1;
          second_word <= cur_cmd.w2;
          third_word <= cur_cmd.w3;
          next_start = 1'b1;
        end
      end
    end
    start <= next_start;
  end

  // Monitor: every done pulse carries one result, which is checked against the oldest item.
  always @(posedge clk) begin
    fifo_outcome_t want;
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result with no item outstanding", 1, 0);
      end else begin
        want = expected_results.pop_front();
        if (read_word !== want.read_word)
          report_mismatch("read_word", read_word, want.read_word);
        if (was_empty !== want.was_empty)
          report_mismatch("was_empty", was_empty, want.was_empty);
        if (push_dropped !== want.push_dropped)
          report_mismatch("push_dropped", push_dropped, want.push_dropped);
        if (fill_count !== want.fill_count)
          report_mismatch("fill_count", fill_count, want.fill_count);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    int random_total;
    int phase_no;
    int mode;
    int len;
    fifo_cmd_t c;
    // Directed opening: empty reads, unused codes, extreme words, flush and reuse.
    cmd_queue.push_back(make_cmd(mwrf_pkg::ACT_POP, 16'h0000, 16'h0000, 16'h0000, 1'b0));
    cmd_queue.push_back(make_cmd(mwrf_pkg::ACT_PEEK, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0));
    cmd_queue.push_back(make_cmd(ACT_SPARE_LO, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0));
    cmd_queue.push_back(make_cmd(mwrf_pkg::ACT_PUSH_TWO, 16'h0000, 16'hFFFF, 16'h1234, 1'b0));
    cmd_queue.push_back(make_cmd(mwrf_pkg::ACT_PUSH_THREE, 16'hFFFF, 16'h0000, 16'h5A5A,
                                 1'b0));
    cmd_queue.push_back(make_cmd(mwrf_pkg::ACT_PEEK, 16'h0000, 16'h0000, 16'h0000, 1'b0));
    cmd_queue.push_back(make_cmd(mwrf_pkg::ACT_POP, 16'h0000, 16'h0000, 16'h0000, 1'b0));
    cmd_queue.push_back(make_cmd(3'd6, 16'hA5A5, 16'h5A5A, 16'hFFFF, 1'b0));
    cmd_queue.push_back(make_cmd(mwrf_pkg::ACT_POP, 16'h0000, 16'h0000, 16'h0000, 1'b0));
    cmd_queue.push_back(make_cmd(mwrf_pkg::ACT_POP, 16'h0000, 16'h0000, 16'h0000, 1'b1));
    cmd_queue.push_back(make_cmd(mwrf_pkg::ACT_PEEK, 16'h0000, 16'h0000, 16'h0000, 1'b0));
    cmd_queue.push_back(make_cmd(mwrf_pkg::ACT_POP, 16'h0000, 16'h0000, 16'h0000, 1'b0));
    cmd_queue.push_back(make_cmd(mwrf_pkg::ACT_POP, 16'h0000, 16'h0000, 16'h0000, 1'b0));
    cmd_queue.push_back(make_cmd(mwrf_pkg::ACT_POP, 16'h0000, 16'h0000, 16'h0000, 1'b0));
    cmd_queue.push_back(make_cmd(ACT_SPARE_HI, 16'h0000, 16'h0000, 16'h0000, 1'b0));
    cmd_queue.push_back(make_cmd(mwrf_pkg::ACT_PUSH_THREE, 16'h8001, 16'h7FFE, 16'hFFFF,
                                 1'b0));
    cmd_queue.push_back(make_cmd(mwrf_pkg::ACT_FLUSH, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1));
    cmd_queue.push_back(make_cmd(mwrf_pkg::ACT_PEEK, 16'h0000, 16'h0000, 16'h0000, 1'b0));
    cmd_queue.push_back(make_cmd(mwrf_pkg::ACT_POP, 16'h0000, 16'h0000, 16'h0000, 1'b0));
    cmd_queue.push_back(make_cmd(mwrf_pkg::ACT_PUSH_TWO, 16'hFFFF, 16'h0000, 16'h0000, 1'b0));
    cmd_queue.push_back(make_cmd(mwrf_pkg::ACT_PEEK, 16'h0000, 16'h0000, 16'h0000, 1'b0));
    cmd_queue.push_back(make_cmd(mwrf_pkg::ACT_FLUSH, 16'h0000, 16'h0000, 16'h0000, 1'b0));

    // Random phases; the first one fills the store so that refused pushes come early.
    random_total = 0;
    phase_no = 0;
    while (random_total < RANDOM_ITEMS) begin
      mode = (phase_no == 0) ? MODE_FILL : $urandom_range(MODE_FILL, MODE_MIXED);
      len = (phase_no == 0) ? 60 : $urandom_range(20, 80);
      for (int i = 0; i < len; i++) begin
        c = random_cmd(mode);
        c.hold = (i == 0) && ($urandom_range(0, 3) == 0);
        cmd_queue.push_back(c);
      end
      random_total += len;
      phase_no++;
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    @(negedge clk);
    while (cmd_queue.size() != 0 || start || in_flight != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (expected_results.size() != 0) begin
      report_mismatch("items left without a result", expected_results.size(), 0);
    end
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
design/mwrf_pkg.sv
design/mwrf_ram.sv
design/multiword_ring_fifo_top.sv
sim/testbench.sv
